// ===== src/kcl_pkg.sv =====
`default_nettype none

package kcl_pkg;

  // keys held per attempt, also the saturation point of the key count
  localparam logic [3:0] MaxKeys = 4'd8;

  localparam logic [7:0] KeyHash = 8'h23;
  localparam logic [7:0] KeyStar = 8'h2A;
  localparam logic [7:0] KeyNone = 8'h5A;

  localparam logic [1:0] ModeIdle    = 2'd0;
  localparam logic [1:0] ModeEntry   = 2'd1;
  localparam logic [1:0] ModeLockout = 2'd2;

  localparam logic [1:0] VerdictNone    = 2'd0;
  localparam logic [1:0] VerdictOk      = 2'd1;
  localparam logic [1:0] VerdictWrong   = 2'd2;
  localparam logic [1:0] VerdictLockout = 2'd3;

  localparam logic [1:0] RegCodeKeys   = 2'd0;
  localparam logic [1:0] RegCodeLength = 2'd1;
  localparam logic [1:0] RegMaxTries   = 2'd2;

  localparam logic [63:0] CodeKeysReset   = 64'h0000_0000_4236_3534;
  localparam logic [3:0]  CodeLengthReset = 4'd4;
  localparam logic [3:0]  MaxTriesReset   = 4'd3;

  typedef struct packed {
    logic [63:0] code_keys;
    logic [3:0]  code_length;
    logic [3:0]  max_tries;
  } cfg_t;

  typedef struct packed {
    logic       action;
    logic [7:0] key_code;
  } item_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] last_key;
    logic [3:0] key_count;
    logic       mismatch;
    logic [3:0] tries;
    logic       unlocked;
  } lock_state_t;

  typedef struct packed {
    logic       lock_open;
    logic       master_engaged;
    logic       entry_active;
    logic [3:0] keys_entered;
    logic [3:0] tries_left;
    logic [1:0] verdict;
  } result_t;

endpackage

`default_nettype wire

// ===== src/kcl_if.sv =====
`default_nettype none

interface kcl_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] key_code;

  modport source (output valid, output action, output key_code, input ready);
  modport sink (input valid, input action, input key_code, output ready);
endinterface

interface kcl_out_if;
  logic       valid;
  logic       ready;
  logic       lock_open;
  logic       master_engaged;
  logic       entry_active;
  logic [3:0] keys_entered;
  logic [3:0] tries_left;
  logic [1:0] verdict;

  modport source (
    output valid, output lock_open, output master_engaged, output entry_active,
    output keys_entered, output tries_left, output verdict, input ready
  );
  modport sink (
    input valid, input lock_open, input master_engaged, input entry_active,
    input keys_entered, input tries_left, input verdict, output ready
  );
endinterface

`default_nettype wire

// ===== src/kcl_cfg_regs.sv =====
`default_nettype none

module kcl_cfg_regs (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_idx_i,
  input  wire logic [63:0]  cfg_data_i,
  output kcl_pkg::cfg_t     cfg_o
);
  import kcl_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.code_keys   <= CodeKeysReset;
      cfg_q.code_length <= CodeLengthReset;
      cfg_q.max_tries   <= MaxTriesReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegCodeKeys:   cfg_q.code_keys   <= cfg_data_i;
        RegCodeLength: cfg_q.code_length <= cfg_data_i[3:0];
        RegMaxTries:   cfg_q.max_tries   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== src/kcl_step.sv =====
`default_nettype none

module kcl_step (
  input  kcl_pkg::cfg_t        cfg_i,
  input  kcl_pkg::lock_state_t state_i,
  input  kcl_pkg::item_t       item_i,
  output kcl_pkg::lock_state_t state_o,
  output kcl_pkg::result_t     result_o
);
  import kcl_pkg::*;

  lock_state_t st;
  logic [1:0]  verdict;
  logic [7:0]  want;
  logic [3:0]  tries_dec;
  logic        match;
  logic        key_new;

  assign want      = cfg_i.code_keys[{state_i.key_count[2:0], 3'b000} +: 8];
  assign tries_dec = (state_i.tries != 4'd0) ? (state_i.tries - 4'd1) : 4'd0;
  assign match     = !state_i.mismatch && (state_i.key_count == cfg_i.code_length);
  assign key_new   = !item_i.action && (item_i.key_code != state_i.last_key) &&
                     (item_i.key_code != KeyNone) && (item_i.key_code != KeyStar);

  always_comb begin
    st      = state_i;
    verdict = VerdictNone;
    unique case (state_i.mode)
      ModeLockout: begin
        if (item_i.action) begin
          st.tries = cfg_i.max_tries;
          st.mode  = ModeIdle;
        end
      end
      ModeEntry: begin
        if (key_new) begin
          st.last_key = item_i.key_code;
          if (item_i.key_code == KeyHash) begin
            // attempt ends: judge, spend or refill tries
            st.key_count = 4'd0;
            st.mismatch  = 1'b0;
            if (match) begin
              st.tries    = cfg_i.max_tries;
              st.unlocked = 1'b1;
              st.mode     = ModeIdle;
              verdict     = VerdictOk;
            end else begin
              st.tries    = tries_dec;
              st.unlocked = 1'b0;
              if (tries_dec == 4'd0) begin
                st.mode = ModeLockout;
                verdict = VerdictLockout;
              end else begin
                st.mode = ModeIdle;
                verdict = VerdictWrong;
              end
            end
          end else if (state_i.key_count < MaxKeys) begin
            if (state_i.key_count >= cfg_i.code_length || want != item_i.key_code) begin
              st.mismatch = 1'b1;
            end
            st.key_count = state_i.key_count + 4'd1;
          end else begin
            // buffer full: overlong entry can never match
            st.mismatch = 1'b1;
          end
        end
      end
      default: begin
        st.mode = ModeIdle;
        if (!item_i.action && item_i.key_code == KeyStar) begin
          st.mode      = ModeEntry;
          st.key_count = 4'd0;
          st.mismatch  = 1'b0;
          st.last_key  = 8'd0;
        end
      end
    endcase
  end

  assign state_o                 = st;
  assign result_o.lock_open      = st.unlocked;
  assign result_o.master_engaged = (st.mode == ModeLockout);
  assign result_o.entry_active   = (st.mode == ModeEntry);
  assign result_o.keys_entered   = st.key_count;
  assign result_o.tries_left     = st.tries;
  assign result_o.verdict        = verdict;

endmodule

`default_nettype wire

// ===== src/keypad_code_lock_with_lockout.sv =====
`default_nettype none

// keypad code lock with retry lockout: each input item is one keypad scan
// sample or a master release, and each gives exactly one result item that
// shows the lock state after it. an item passes an input register, then the
// decision logic (a few byte compares and a 4-bit decrement) into a result
// register, so the block takes one item per cycle while the result register
// drains, and a stalled result keeps the next item in the input register;
// throughput is bounded only by the result register draining. configuration
// is to be written by the user through the plain write port while no item is
// in flight; the block itself does not enforce this.

module keypad_code_lock_with_lockout (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_data_i,
  kcl_in_if.sink       in_chan_i,
  kcl_out_if.source    out_chan_o
);
  import kcl_pkg::*;

  cfg_t        cfg;
  item_t       in_q;
  logic        in_vld_q;
  result_t     res_q;
  result_t     res_d;
  logic        res_vld_q;
  lock_state_t state_q;
  lock_state_t state_d;
  logic        in_acc;
  logic        adv;
  logic        move;

  kcl_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // result register free or draining this cycle
  assign adv    = !res_vld_q || out_chan_o.ready;
  // buffered item goes through the decision logic
  assign move   = in_vld_q && adv;
  assign in_chan_i.ready = !in_vld_q || move;
  assign in_acc = in_chan_i.valid && in_chan_i.ready;

  kcl_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .item_i   (in_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_acc) begin
      in_vld_q <= 1'b1;
    end else if (move) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q.action   <= in_chan_i.action;
      in_q.key_code <= in_chan_i.key_code;
    end
  end

  // lock state, updated once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode      <= ModeIdle;
      state_q.last_key  <= 8'd0;
      state_q.key_count <= 4'd0;
      state_q.mismatch  <= 1'b0;
      state_q.tries     <= MaxTriesReset;
      state_q.unlocked  <= 1'b0;
    end else if (move) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (move) begin
      res_vld_q <= 1'b1;
    end else if (out_chan_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      res_q <= res_d;
    end
  end

  assign out_chan_o.valid          = res_vld_q;
  assign out_chan_o.lock_open      = res_q.lock_open;
  assign out_chan_o.master_engaged = res_q.master_engaged;
  assign out_chan_o.entry_active   = res_q.entry_active;
  assign out_chan_o.keys_entered   = res_q.keys_entered;
  assign out_chan_o.tries_left     = res_q.tries_left;
  assign out_chan_o.verdict        = res_q.verdict;

endmodule

`default_nettype wire

// ===== src/kcl_checker.sv =====
`default_nettype none

module kcl_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic       lock_open_i,
  input wire logic       master_engaged_i,
  input wire logic       entry_active_i,
  input wire logic [3:0] keys_entered_i,
  input wire logic [3:0] tries_left_i,
  input wire logic [1:0] verdict_i
);
  import kcl_pkg::*;

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(verdict_i) &&
      $stable(tries_left_i) && $stable(lock_open_i))
    else $error("result changed while stalled");

  // a correct code opens the lock and closes the attempt
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && verdict_i == VerdictOk |->
      lock_open_i && !entry_active_i && !master_engaged_i && keys_entered_i == 4'd0)
    else $error("correct verdict with inconsistent state");

  // lockout keeps the lock shut with no tries left
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && master_engaged_i |-> !lock_open_i && tries_left_i == 4'd0 &&
      !entry_active_i)
    else $error("lockout with lock open or tries left");

  // lockout verdict only when entering lockout
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && verdict_i == VerdictLockout |-> master_engaged_i)
    else $error("lockout verdict without lockout");

  // key count never passes the buffer size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> keys_entered_i <= MaxKeys)
    else $error("key count beyond buffer");

endmodule

bind keypad_code_lock_with_lockout kcl_checker u_kcl_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_chan_o.valid),
  .out_ready_i      (out_chan_o.ready),
  .lock_open_i      (out_chan_o.lock_open),
  .master_engaged_i (out_chan_o.master_engaged),
  .entry_active_i   (out_chan_o.entry_active),
  .keys_entered_i   (out_chan_o.keys_entered),
  .tries_left_i     (out_chan_o.tries_left),
  .verdict_i        (out_chan_o.verdict)
);

`default_nettype wire
